// ===== sv/keyvalue_text_tokenizer_macros.svh =====
// Assertion macros for the key-value text tokenizer checker
`ifndef KEYVALUE_TEXT_TOKENIZER_MACROS_SVH
`define KEYVALUE_TEXT_TOKENIZER_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define KVT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define KVT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/kvt_pkg.sv =====
// Shared types and constants of the key-value text tokenizer
package kvt_pkg;

  // Nesting limit; the level register is 8 bits, so the cap saturates at 255
  localparam int MAX_DEPTH     = 255;
  localparam int DEPTH_CAP_INT = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;
  localparam logic [7:0] DEPTH_CAP = 8'(DEPTH_CAP_INT);

  // Most events one item can cause
  localparam int KVT_MAX_EV = 5;
  localparam int KVT_CNT_W  = $clog2(KVT_MAX_EV + 1);

  // Characters
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  typedef enum logic [3:0] {
    EV_SSTART = 4'd0,
    EV_SCHAR  = 4'd1,
    EV_SEND   = 4'd2,
    EV_CSTART = 4'd3,
    EV_CCHAR  = 4'd4,
    EV_CEND   = 4'd5,
    EV_OPEN   = 4'd6,
    EV_CLOSE  = 4'd7,
    EV_DOCEND = 4'd8,
    EV_ERROR  = 4'd9
  } kvt_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_STRAY    = 3'd1,
    ERR_QUOTE    = 3'd2,
    ERR_BRACE    = 3'd3,
    ERR_OVERFLOW = 3'd4
  } kvt_err_t;

  // One input item
  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       doc_last;
  } kvt_item_t;

  // One token event
  typedef struct packed {
    kvt_kind_t  kind;
    logic [7:0] ch;
    logic [7:0] level;
    kvt_err_t   err;
    logic       last;
  } kvt_event_t;

  // All events of one item, slot 0 first
  typedef struct packed {
    logic [KVT_CNT_W-1:0]           n;
    kvt_event_t [KVT_MAX_EV-1:0]    ev;
  } kvt_step_t;

  // Event queue status toward the top level
  typedef struct packed {
    logic valid;  // head event present
    logic one;    // exactly one event left
  } kvt_qstat_t;

endpackage

// ===== sv/kvt_if.sv =====
// Valid/ready channel interfaces for input items and token events
interface kvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       has_byte;
  logic       doc_last;

  modport source (output valid, in_byte, has_byte, doc_last, input ready);
  modport sink   (input valid, in_byte, has_byte, doc_last, output ready);
endinterface

interface kvt_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] event_kind;
  logic [7:0] char_out;
  logic [7:0] level;
  logic [2:0] error_code;
  logic       run_last;

  modport source (output valid, event_kind, char_out, level, error_code, run_last,
                  input ready);
  modport sink   (input valid, event_kind, char_out, level, error_code, run_last,
                  output ready);
endinterface

// ===== sv/kvt_lexer.sv =====
// Lexer state and single-pass event generation for one item
module kvt_lexer (
  input  logic               clk,
  input  logic               rst_n,
  input  kvt_pkg::kvt_item_t item,
  input  logic               step_en,
  output kvt_pkg::kvt_step_t step
);
  import kvt_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE  = 3'd0,
    M_QSTR  = 3'd1,
    M_USTR  = 3'd2,
    M_SLASH = 3'd3,
    M_CMT   = 3'd4,
    M_HALT  = 3'd5
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] level_r, level_nxt;

  function automatic logic is_space(logic [7:0] c);
    return c inside {CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR, CH_SP};
  endfunction

  function automatic kvt_event_t mk_ev(kvt_kind_t k, logic [7:0] ch, logic [7:0] lv,
                                       kvt_err_t e);
    kvt_event_t r;
    r.kind  = k;
    r.ch    = ch;
    r.level = lv;
    r.err   = e;
    r.last  = 1'b0;
    return r;
  endfunction

  // Byte handling, then end-of-document handling, in one pass
  always_comb begin
    mode_t                    m;
    logic [7:0]               lvl;
    logic [7:0]               c;
    logic [KVT_CNT_W-1:0]     n;
    kvt_event_t [KVT_MAX_EV-1:0] ev;
    logic                     done;
    m    = mode_r;
    lvl  = level_r;
    c    = item.in_byte;
    n    = '0;
    ev   = '0;
    done = 1'b0;

    if (item.has_byte) begin
      case (m)
        M_HALT: begin
        end
        M_QSTR: begin
          if (c == CH_QUOTE) begin
            ev[n] = mk_ev(EV_SEND, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
            m = M_IDLE;
          end else begin
            ev[n] = mk_ev(EV_SCHAR, c, 8'd0, ERR_NONE); n = n + 1'b1;
          end
        end
        M_USTR: begin
          if (is_space(c) || c == CH_NUL) begin
            ev[n] = mk_ev(EV_SEND, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
            m = M_IDLE;
          end else begin
            ev[n] = mk_ev(EV_SCHAR, c, 8'd0, ERR_NONE); n = n + 1'b1;
          end
        end
        M_CMT: begin
          if (c == CH_NL) begin
            ev[n] = mk_ev(EV_CEND, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
            m = M_IDLE;
          end else begin
            ev[n] = mk_ev(EV_CCHAR, c, 8'd0, ERR_NONE); n = n + 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            ev[n] = mk_ev(EV_CSTART, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
            m = M_CMT;
          end else begin
            // held slash opens an unquoted string, then this byte continues or ends it
            ev[n] = mk_ev(EV_SSTART, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
            ev[n] = mk_ev(EV_SCHAR, CH_SLASH, 8'd0, ERR_NONE); n = n + 1'b1;
            if (is_space(c) || c == CH_NUL) begin
              ev[n] = mk_ev(EV_SEND, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
              m = M_IDLE;
            end else begin
              ev[n] = mk_ev(EV_SCHAR, c, 8'd0, ERR_NONE); n = n + 1'b1;
              m = M_USTR;
            end
          end
        end
        default: begin
          m = M_IDLE;
          if (is_space(c) || c == CH_NUL) begin
          end else if (c == CH_LBRACE) begin
            if (lvl >= DEPTH_CAP) begin
              ev[n] = mk_ev(EV_ERROR, 8'd0, 8'd0, ERR_OVERFLOW); n = n + 1'b1;
              m = M_HALT;
            end else begin
              ev[n] = mk_ev(EV_OPEN, 8'd0, lvl, ERR_NONE); n = n + 1'b1;
              lvl = lvl + 8'd1;
            end
          end else if (c == CH_RBRACE) begin
            if (lvl == 8'd0) begin
              ev[n] = mk_ev(EV_ERROR, 8'd0, 8'd0, ERR_STRAY); n = n + 1'b1;
              m = M_HALT;
            end else begin
              lvl = lvl - 8'd1;
              ev[n] = mk_ev(EV_CLOSE, 8'd0, lvl, ERR_NONE); n = n + 1'b1;
            end
          end else if (c == CH_QUOTE) begin
            ev[n] = mk_ev(EV_SSTART, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
            m = M_QSTR;
          end else if (c == CH_SLASH) begin
            m = M_SLASH;
          end else begin
            ev[n] = mk_ev(EV_SSTART, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
            ev[n] = mk_ev(EV_SCHAR, c, 8'd0, ERR_NONE); n = n + 1'b1;
            m = M_USTR;
          end
        end
      endcase
    end

    if (item.doc_last) begin
      case (m)
        M_HALT: done = 1'b1;
        M_QSTR: begin
          ev[n] = mk_ev(EV_ERROR, 8'd0, 8'd0, ERR_QUOTE); n = n + 1'b1;
          done = 1'b1;
        end
        M_USTR: begin
          ev[n] = mk_ev(EV_SEND, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
        end
        M_SLASH: begin
          // lone trailing slash becomes a one-character string
          ev[n] = mk_ev(EV_SSTART, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
          ev[n] = mk_ev(EV_SCHAR, CH_SLASH, 8'd0, ERR_NONE); n = n + 1'b1;
          ev[n] = mk_ev(EV_SEND, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
        end
        M_CMT: begin
          ev[n] = mk_ev(EV_CEND, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
        end
        default: begin
        end
      endcase
      if (!done) begin
        if (lvl != 8'd0) begin
          ev[n] = mk_ev(EV_ERROR, 8'd0, 8'd0, ERR_BRACE); n = n + 1'b1;
        end else begin
          ev[n] = mk_ev(EV_DOCEND, 8'd0, 8'd0, ERR_NONE); n = n + 1'b1;
        end
      end
      m   = M_IDLE;
      lvl = 8'd0;
    end

    // flag the final event of this item
    if (n != '0) begin
      ev[n - 1'b1].last = 1'b1;
    end

    step.n    = n;
    step.ev   = ev;
    mode_nxt  = m;
    level_nxt = lvl;
  end

  // Lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      level_r <= 8'd0;
    end else if (step_en) begin
      mode_r  <= mode_nxt;
      level_r <= level_nxt;
    end
  end

endmodule

// ===== sv/kvt_evq.sv =====
// Result register queue: loads all events of one item, drains one per transfer
module kvt_evq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  kvt_pkg::kvt_step_t  step,
  input  logic                pop,
  output kvt_pkg::kvt_event_t head,
  output kvt_pkg::kvt_qstat_t stat
);
  import kvt_pkg::*;

  kvt_event_t [KVT_MAX_EV-1:0] ent_r;
  logic [KVT_CNT_W-1:0]        cnt_r;

  // Count of events waiting
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= step.n;
    end else if (pop && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Event slots, shifted toward slot 0 on each transfer
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= step.ev;
    end else if (pop) begin
      for (int i = 0; i < KVT_MAX_EV - 1; i++) begin
        ent_r[i] <= ent_r[i + 1];
      end
    end
  end

  assign head       = ent_r[0];
  assign stat.valid = (cnt_r != '0);
  assign stat.one   = (cnt_r == KVT_CNT_W'(1));

endmodule

// ===== sv/keyvalue_text_tokenizer.sv =====
// Top level of the key-value text tokenizer
//
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    in_byte[7:0], has_byte, doc_last
//  out_ch   out  valid/ready    event_kind[3:0], char_out[7:0], level[7:0],
//                               error_code[2:0], run_last
//
// An item is registered, lexed in one pass and its 0..5 events loaded into
// the result queue, which sends one event per cycle while out_ch is ready.
// The next item loads as the last event of the previous one leaves.
// The first event passes through the input register, then the result queue.
// rst_n is synchronous, active low: state to idle, level zero, queue empty.
// A stalled output holds the input register, which then stalls in_ch.
module keyvalue_text_tokenizer (
  input  logic      clk,
  input  logic      rst_n,
  kvt_in_if.sink    in_ch,
  kvt_out_if.source out_ch
);
  import kvt_pkg::*;

  kvt_item_t  item_r;
  logic       item_v_r;
  kvt_step_t  step;
  kvt_event_t head;
  kvt_qstat_t qstat;
  logic       pop;
  logic       load;
  logic       in_fire;

  assign pop     = out_ch.valid && out_ch.ready;
  // queue empty, or its last event leaves this cycle
  assign load    = item_v_r && (!qstat.valid || (qstat.one && pop));
  assign in_ch.ready = !item_v_r || load;
  assign in_fire = in_ch.valid && in_ch.ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_fire) begin
      item_v_r <= 1'b1;
    end else if (load) begin
      item_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.in_byte  <= in_ch.in_byte;
      item_r.has_byte <= in_ch.has_byte;
      item_r.doc_last <= in_ch.doc_last;
    end
  end

  kvt_lexer u_lexer (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item_r),
    .step_en (load),
    .step    (step)
  );

  kvt_evq u_evq (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .step  (step),
    .pop   (pop),
    .head  (head),
    .stat  (qstat)
  );

  // Output channel
  assign out_ch.valid      = qstat.valid;
  assign out_ch.event_kind = head.kind;
  assign out_ch.char_out   = head.ch;
  assign out_ch.level      = head.level;
  assign out_ch.error_code = head.err;
  assign out_ch.run_last   = head.last;

endmodule

// ===== sv/kvt_checker.sv =====
// Port-level checker for the key-value text tokenizer, with its bind
`include "keyvalue_text_tokenizer_macros.svh"

module kvt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] event_kind,
  input logic [7:0] char_out,
  input logic [7:0] level,
  input logic [2:0] error_code,
  input logic       run_last
);
  import kvt_pkg::*;

  // Stalled event stays offered
  `KVT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "out valid dropped")

  // Stalled event payload holds
  `KVT_ASSERT_NXT(a_out_stable, out_valid && !out_ready,
    $stable(event_kind) && $stable(char_out) && $stable(level) && $stable(error_code) && $stable(run_last),
    "out payload changed while stalled")

  // Doc end and error close the item's run
  `KVT_ASSERT_IMP(a_end_last, out_valid && (event_kind == EV_DOCEND || event_kind == EV_ERROR),
    run_last, "document end event without run_last")

  // Input side ready right after reset
  `KVT_ASSERT_IMP(a_ready_after_rst, $past(!rst_n), in_ready, "not ready after reset")

endmodule

bind keyvalue_text_tokenizer kvt_checker u_kvt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .event_kind (out_ch.event_kind),
  .char_out   (out_ch.char_out),
  .level      (out_ch.level),
  .error_code (out_ch.error_code),
  .run_last   (out_ch.run_last)
);
